/* src/ubtrq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubtrq_pkg
// shared codes and defaults for the buffered uart transmit / receive queues
// ----------------------------------------------------------------------------
package ubtrq_pkg;

   localparam int TX_DEPTH_DEFAULT = 32;
   localparam int RX_DEPTH_DEFAULT = 32;

   localparam int CMD_W    = 2;
   localparam int BYTE_W   = 8;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 6;

   typedef logic [CMD_W-1:0]    cmd_type;
   typedef logic [STATUS_W-1:0] status_type;

   // event codes
   localparam cmd_type CMD_PUT     = 2'd0;
   localparam cmd_type CMD_TX_DONE = 2'd1;
   localparam cmd_type CMD_RX_BYTE = 2'd2;
   localparam cmd_type CMD_READ    = 2'd3;

   // status codes
   localparam status_type ST_OK         = 2'd0;
   localparam status_type ST_TX_DROP    = 2'd1;
   localparam status_type ST_RX_DROP    = 2'd2;
   localparam status_type ST_READ_EMPTY = 2'd3;

endpackage

/* src/uart_buffered_tx_rx_queues.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_buffered_tx_rx_queues
// transmit queue and receive ring of a buffered uart front end
// ----------------------------------------------------------------------------
// usage
//  - req channel: one event per request (put, transmit done, byte received,
//    read); accepted on a rising edge with req_valid high and req_stall low
//  - rsp channel: exactly one result per request, in order; taken on a
//    rising edge with rsp_valid high and rsp_stall low
//  - path: an accepted request is held in the input register, and its result
//    is then registered in the result register
//  - throughput: one request per cycle while no result is stalled, set by
//    the single pass of pointer logic between the input register and the
//    result register; each ring memory has one write port and one registered
//    read port that keeps the oldest entry prefetched for the next read
//  - stall: when the result register holds a result that is stalled, the
//    input register holds its request and req_stall rises once both hold
//  - reset (synchronous): both queues empty, transmitter idle, no request
//    or result in flight; the ring memories are not cleared, an entry is
//    only read after it is written
// ----------------------------------------------------------------------------
module uart_buffered_tx_rx_queues #(
   parameter int TX_DEPTH = ubtrq_pkg::TX_DEPTH_DEFAULT,
   parameter int RX_DEPTH = ubtrq_pkg::RX_DEPTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,

   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [ubtrq_pkg::CMD_W-1:0]    req_cmd,
   input  logic [ubtrq_pkg::BYTE_W-1:0]   req_data_byte,

   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_tx_load_valid,
   output logic [ubtrq_pkg::BYTE_W-1:0]   rsp_tx_load_byte,
   output logic                           rsp_read_valid,
   output logic [ubtrq_pkg::BYTE_W-1:0]   rsp_read_byte,
   output logic [ubtrq_pkg::STATUS_W-1:0] rsp_status,
   output logic                           rsp_tx_full,
   output logic                           rsp_tx_busy,
   output logic [ubtrq_pkg::COUNT_W-1:0]  rsp_rx_count
);

   // tx pointers index the queue directly, rx pointers run modulo twice the depth
   localparam int TX_AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
   localparam int RX_AW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
   localparam int RX_PW = $clog2(2 * RX_DEPTH);
   localparam int BW    = ubtrq_pkg::BYTE_W;
   localparam int CW    = ubtrq_pkg::COUNT_W;

   localparam logic [TX_AW-1:0] TX_LAST  = TX_AW'(TX_DEPTH - 1);
   localparam logic [RX_PW-1:0] RX_LAST  = RX_PW'(2 * RX_DEPTH - 1);
   localparam logic [RX_PW-1:0] RX_DEP_P = RX_PW'(RX_DEPTH);
   localparam logic [RX_PW:0]   RX_SPAN  = (RX_PW + 1)'(2 * RX_DEPTH);

   // ring memories
   logic [BW-1:0] tx_mem [TX_DEPTH];
   logic [BW-1:0] rx_mem [RX_DEPTH];

   // input register
   logic                  in_valid_ff, in_valid_in;
   ubtrq_pkg::cmd_type    in_cmd_ff;
   logic [BW-1:0]         in_data_ff;

   // queue state
   logic [TX_AW-1:0] tx_wr_ptr_ff, tx_wr_ptr_in;
   logic [TX_AW-1:0] tx_rd_ptr_ff, tx_rd_ptr_in;
   logic             tx_full_ff, tx_full_in;
   logic             tx_active_ff, tx_active_in;
   logic [RX_PW-1:0] rx_wr_ptr_ff, rx_wr_ptr_in;
   logic [RX_PW-1:0] rx_rd_ptr_ff, rx_rd_ptr_in;

   // prefetched oldest entries of each ring
   logic [BW-1:0] tx_head_ff;
   logic [BW-1:0] rx_head_ff;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  load_valid_ff, load_valid_in;
   logic [BW-1:0]         load_byte_ff, load_byte_in;
   logic                  rd_valid_ff, rd_valid_in;
   logic [BW-1:0]         rd_byte_ff, rd_byte_in;
   ubtrq_pkg::status_type status_ff, status_in;
   logic                  tx_full_out_ff;
   logic                  tx_busy_out_ff;
   logic [CW-1:0]         rx_count_ff, rx_count_in;

   // handshake
   logic accept;
   logic rsp_free;
   logic fire;

   // memory port controls
   logic             tx_we;
   logic             rx_we;
   logic [RX_AW-1:0] rx_wr_slot;
   logic [RX_AW-1:0] rx_rd_slot_in;

   // rx fill levels before and after the step
   logic [RX_PW-1:0]  rx_level;
   logic [RX_PW-1:0]  rx_level_in;
   logic [RX_PW+CW:0] rx_level_ext;

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && rsp_free;
   assign req_stall = in_valid_ff && !rsp_free;
   assign accept    = req_valid && !req_stall;

   // fill level as (write - read) modulo twice the depth
   always_comb begin
      if (rx_wr_ptr_ff >= rx_rd_ptr_ff) begin
         rx_level = rx_wr_ptr_ff - rx_rd_ptr_ff;
      end else begin
         rx_level = RX_PW'({1'b0, rx_wr_ptr_ff} + RX_SPAN - {1'b0, rx_rd_ptr_ff});
      end
      if (rx_wr_ptr_in >= rx_rd_ptr_in) begin
         rx_level_in = rx_wr_ptr_in - rx_rd_ptr_in;
      end else begin
         rx_level_in = RX_PW'({1'b0, rx_wr_ptr_in} + RX_SPAN - {1'b0, rx_rd_ptr_in});
      end
   end

   // ring slot of an rx pointer
   always_comb begin
      if (rx_wr_ptr_ff >= RX_DEP_P) begin
         rx_wr_slot = RX_AW'(rx_wr_ptr_ff - RX_DEP_P);
      end else begin
         rx_wr_slot = RX_AW'(rx_wr_ptr_ff);
      end
      if (rx_rd_ptr_in >= RX_DEP_P) begin
         rx_rd_slot_in = RX_AW'(rx_rd_ptr_in - RX_DEP_P);
      end else begin
         rx_rd_slot_in = RX_AW'(rx_rd_ptr_in);
      end
   end

   // single pass event logic
   always_comb begin
      tx_wr_ptr_in  = tx_wr_ptr_ff;
      tx_rd_ptr_in  = tx_rd_ptr_ff;
      tx_full_in    = tx_full_ff;
      tx_active_in  = tx_active_ff;
      rx_wr_ptr_in  = rx_wr_ptr_ff;
      rx_rd_ptr_in  = rx_rd_ptr_ff;
      tx_we         = 1'b0;
      rx_we         = 1'b0;
      load_valid_in = 1'b0;
      load_byte_in  = '0;
      rd_valid_in   = 1'b0;
      rd_byte_in    = '0;
      status_in     = ubtrq_pkg::ST_OK;

      if (fire) begin
         case (in_cmd_ff)
            ubtrq_pkg::CMD_PUT: begin
               if (tx_full_ff) begin
                  status_in = ubtrq_pkg::ST_TX_DROP;
               end else if (!tx_active_ff) begin
                  // idle transmitter, byte bypasses the queue
                  tx_active_in  = 1'b1;
                  load_valid_in = 1'b1;
                  load_byte_in  = in_data_ff;
               end else begin
                  tx_we        = 1'b1;
                  tx_wr_ptr_in = (tx_wr_ptr_ff == TX_LAST) ? '0 : tx_wr_ptr_ff + 1'b1;
                  if (tx_wr_ptr_in == tx_rd_ptr_ff) begin
                     tx_full_in = 1'b1;
                  end
               end
            end
            ubtrq_pkg::CMD_TX_DONE: begin
               if (tx_active_ff && (tx_full_ff || (tx_rd_ptr_ff != tx_wr_ptr_ff))) begin
                  load_valid_in = 1'b1;
                  load_byte_in  = tx_head_ff;
                  tx_rd_ptr_in  = (tx_rd_ptr_ff == TX_LAST) ? '0 : tx_rd_ptr_ff + 1'b1;
                  tx_full_in    = 1'b0;
               end else begin
                  tx_active_in = 1'b0;
               end
            end
            ubtrq_pkg::CMD_RX_BYTE: begin
               if (rx_level >= RX_DEP_P) begin
                  status_in = ubtrq_pkg::ST_RX_DROP;
               end else begin
                  rx_we        = 1'b1;
                  rx_wr_ptr_in = (rx_wr_ptr_ff == RX_LAST) ? '0 : rx_wr_ptr_ff + 1'b1;
               end
            end
            ubtrq_pkg::CMD_READ: begin
               if (rx_level == '0) begin
                  status_in = ubtrq_pkg::ST_READ_EMPTY;
               end else begin
                  rd_valid_in  = 1'b1;
                  rd_byte_in   = rx_head_ff;
                  rx_rd_ptr_in = (rx_rd_ptr_ff == RX_LAST) ? '0 : rx_rd_ptr_ff + 1'b1;
               end
            end
            default: begin
               status_in = ubtrq_pkg::ST_OK;
            end
         endcase
      end
   end

   // rx_count carries the low bits of the level
   assign rx_level_ext = {{(CW + 1){1'b0}}, rx_level_in};
   assign rx_count_in  = rx_level_ext[CW-1:0];

   always_comb begin
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_free) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         tx_wr_ptr_ff <= '0;
         tx_rd_ptr_ff <= '0;
         tx_full_ff   <= 1'b0;
         tx_active_ff <= 1'b0;
         rx_wr_ptr_ff <= '0;
         rx_rd_ptr_ff <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         tx_wr_ptr_ff <= tx_wr_ptr_in;
         tx_rd_ptr_ff <= tx_rd_ptr_in;
         tx_full_ff   <= tx_full_in;
         tx_active_ff <= tx_active_in;
         rx_wr_ptr_ff <= rx_wr_ptr_in;
         rx_rd_ptr_ff <= rx_rd_ptr_in;
      end
   end

   // input register payload
   always_ff @(posedge clock) begin
      if (accept) begin
         in_cmd_ff  <= req_cmd;
         in_data_ff <= req_data_byte;
      end
   end

   // result register payload
   always_ff @(posedge clock) begin
      if (fire) begin
         load_valid_ff  <= load_valid_in;
         load_byte_ff   <= load_byte_in;
         rd_valid_ff    <= rd_valid_in;
         rd_byte_ff     <= rd_byte_in;
         status_ff      <= status_in;
         tx_full_out_ff <= tx_full_in;
         tx_busy_out_ff <= tx_active_in;
         rx_count_ff    <= rx_count_in;
      end
   end

   // tx ring: write at the write pointer, keep the next head prefetched
   always_ff @(posedge clock) begin
      if (tx_we) begin
         tx_mem[tx_wr_ptr_ff] <= in_data_ff;
      end
      if (tx_we && (tx_wr_ptr_ff == tx_rd_ptr_in)) begin
         tx_head_ff <= in_data_ff;
      end else begin
         tx_head_ff <= tx_mem[tx_rd_ptr_in];
      end
   end

   // rx ring: same scheme, slots folded from the wider pointers
   always_ff @(posedge clock) begin
      if (rx_we) begin
         rx_mem[rx_wr_slot] <= in_data_ff;
      end
      if (rx_we && (rx_wr_slot == rx_rd_slot_in)) begin
         rx_head_ff <= in_data_ff;
      end else begin
         rx_head_ff <= rx_mem[rx_rd_slot_in];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_tx_load_valid = load_valid_ff;
   assign rsp_tx_load_byte  = load_byte_ff;
   assign rsp_read_valid    = rd_valid_ff;
   assign rsp_read_byte     = rd_byte_ff;
   assign rsp_status        = status_ff;
   assign rsp_tx_full       = tx_full_out_ff;
   assign rsp_tx_busy       = tx_busy_out_ff;
   assign rsp_rx_count      = rx_count_ff;

endmodule
